### sv/qdd_pkg.sv
// shared types, constants and helper functions of the dedup queue
package qdd_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_DEDUP = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MARK,
    S_COMPACT
  } state_e;

  typedef logic [DATA_WIDTH-1:0] word_t;

  // per-cycle commands broadcast along the row of cells
  typedef struct packed {
    logic enq;
    logic deq;
    logic compact;
    logic mark;
  } cell_ctl_t;

  // keep the low stored bits of a sign-extended input word
  function automatic word_t to_word(logic signed [31:0] v);
    logic signed [63:0] ext;
    ext = 64'(v);
    return ext[DATA_WIDTH-1:0];
  endfunction

  // sign-extend a stored word and return its low 32 bits
  function automatic logic [31:0] from_word(word_t w);
    logic signed [63:0] ext;
    ext = 64'(signed'(w));
    return ext[31:0];
  endfunction

endpackage

### sv/fifo_queue_with_dedup.sv
// Bounded FIFO of signed words with enqueue, dequeue and duplicate removal.
// A transaction is taken on a clock edge with start high and busy low; its result
// shows for exactly one cycle with valid_o high and cannot be held off by the
// receiver. For enqueue, dequeue and the unused op code the result appears the
// cycle after acceptance and busy stays low, so one transaction per cycle is
// taken while no dedup walk holds busy high. Dedup of a non-empty queue runs on
// the row of entry cells: a mark state compares each held entry against all
// later entries, then a compact state removes the duplicates one at a time, and
// the result shows in the cycle after compaction ends; busy stays high until its
// result. entry_count_o is the count held after the transaction.
module fifo_queue_with_dedup (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op_i,
  input  logic signed [31:0] value_i,
  output logic               valid_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] data_out_o,
  output logic [4:0]         entry_count_o
);

  qdd_pkg::cell_ctl_t            ctl;
  qdd_pkg::word_t                wdata;
  qdd_pkg::word_t                cell_data [qdd_pkg::DEPTH];
  logic [qdd_pkg::DEPTH-1:0]     cell_dup;
  logic [qdd_pkg::DEPTH:0]       hole;
  logic [qdd_pkg::CNT_W-1:0]     count;
  logic [qdd_pkg::IDX_W-1:0]     probe_idx;
  logic [31:0]                   dout;
  qdd_pkg::word_t                probe;

  assign hole[0] = 1'b0;
  assign probe   = cell_data[probe_idx];

  // sequencer
  qdd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .op_i        (op_i),
    .value_i     (value_i),
    .head_data_i (cell_data[0]),
    .any_dup_i   (hole[qdd_pkg::DEPTH]),
    .busy_o      (busy),
    .valid_o     (valid_o),
    .status_o    (status_o),
    .data_out_o  (dout),
    .count_o     (count),
    .probe_idx_o (probe_idx),
    .ctl_o       (ctl),
    .wdata_o     (wdata)
  );

  // row of entry cells, head at index zero
  for (genvar i = 0; i < qdd_pkg::DEPTH; i++) begin : g_cell
    logic           wr_sel;
    logic           mark_sel;
    qdd_pkg::word_t nbr_data;
    logic           nbr_dup;

    assign wr_sel   = (count == qdd_pkg::CNT_W'(i));
    assign mark_sel = (qdd_pkg::CNT_W'(i) > qdd_pkg::CNT_W'(probe_idx)) &&
                      (qdd_pkg::CNT_W'(i) < count);

    if (i < qdd_pkg::DEPTH - 1) begin : g_mid
      assign nbr_data = cell_data[i+1];
      assign nbr_dup  = cell_dup[i+1];
    end else begin : g_last
      assign nbr_data = cell_data[i];
      assign nbr_dup  = 1'b0;
    end

    qdd_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .wr_sel_i   (wr_sel),
      .mark_sel_i (mark_sel),
      .wdata_i    (wdata),
      .probe_i    (probe),
      .nbr_data_i (nbr_data),
      .nbr_dup_i  (nbr_dup),
      .hole_i     (hole[i]),
      .data_o     (cell_data[i]),
      .dup_o      (cell_dup[i]),
      .hole_o     (hole[i+1])
    );
  end

  assign data_out_o    = signed'(dout);
  assign entry_count_o = 5'(count);

endmodule

### sv/qdd_cell.sv
// one queue entry: data word, duplicate flag and shift towards the head
module qdd_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qdd_pkg::cell_ctl_t  ctl_i,
  input  logic                wr_sel_i,
  input  logic                mark_sel_i,
  input  qdd_pkg::word_t      wdata_i,
  input  qdd_pkg::word_t      probe_i,
  input  qdd_pkg::word_t      nbr_data_i,
  input  logic                nbr_dup_i,
  input  logic                hole_i,
  output qdd_pkg::word_t      data_o,
  output logic                dup_o,
  output logic                hole_o
);

  qdd_pkg::word_t data_q, data_d;
  logic           dup_q, dup_d;
  logic           shift;

  // take the neighbour's contents on a dequeue, or from the first duplicate onward
  assign shift  = ctl_i.deq | (ctl_i.compact & (hole_i | dup_q));
  assign hole_o = hole_i | dup_q;

  // data path
  always_comb begin
    data_d = data_q;
    if (shift) begin
      data_d = nbr_data_i;
    end else if (ctl_i.enq && wr_sel_i) begin
      data_d = wdata_i;
    end
  end

  // duplicate flag
  always_comb begin
    dup_d = dup_q;
    if (shift) begin
      dup_d = nbr_dup_i;
    end else if (ctl_i.mark && mark_sel_i && (data_q == probe_i)) begin
      dup_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dup_q <= 1'b0;
    end else begin
      dup_q <= dup_d;
    end
  end

  assign data_o = data_q;
  assign dup_o  = dup_q;

endmodule

### sv/qdd_ctrl.sv
// sequencer: operation decode, entry count, dedup walk and result register
module qdd_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [1:0]                    op_i,
  input  logic signed [31:0]            value_i,
  input  qdd_pkg::word_t                head_data_i,
  input  logic                          any_dup_i,
  output logic                          busy_o,
  output logic                          valid_o,
  output logic [1:0]                    status_o,
  output logic [31:0]                   data_out_o,
  output logic [qdd_pkg::CNT_W-1:0]     count_o,
  output logic [qdd_pkg::IDX_W-1:0]     probe_idx_o,
  output qdd_pkg::cell_ctl_t            ctl_o,
  output qdd_pkg::word_t                wdata_o
);

  qdd_pkg::state_e               state_q, state_d;
  logic [qdd_pkg::CNT_W-1:0]     count_q, count_d;
  logic [qdd_pkg::IDX_W-1:0]     k_q, k_d;
  logic                          valid_q, valid_d;
  qdd_pkg::status_e              status_q, status_d;
  logic [31:0]                   dout_q, dout_d;
  logic                          full, empty;

  assign full  = (count_q == qdd_pkg::CNT_W'(qdd_pkg::DEPTH));
  assign empty = (count_q == '0);

  // next state, commands to the cells and result
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    k_d      = k_q;
    valid_d  = 1'b0;
    status_d = status_q;
    dout_d   = dout_q;
    ctl_o    = '0;
    unique case (state_q)
      qdd_pkg::S_IDLE: begin
        if (start_i) begin
          unique case (qdd_pkg::op_e'(op_i))
            qdd_pkg::OP_ENQ: begin
              valid_d = 1'b1;
              dout_d  = '0;
              if (full) begin
                status_d = qdd_pkg::ST_FULL;
              end else begin
                status_d  = qdd_pkg::ST_OK;
                ctl_o.enq = 1'b1;
                count_d   = count_q + qdd_pkg::CNT_W'(1);
              end
            end
            qdd_pkg::OP_DEQ: begin
              valid_d = 1'b1;
              if (empty) begin
                status_d = qdd_pkg::ST_EMPTY;
                dout_d   = '0;
              end else begin
                status_d  = qdd_pkg::ST_OK;
                dout_d    = qdd_pkg::from_word(head_data_i);
                ctl_o.deq = 1'b1;
                count_d   = count_q - qdd_pkg::CNT_W'(1);
              end
            end
            qdd_pkg::OP_DEDUP: begin
              if (empty) begin
                valid_d  = 1'b1;
                status_d = qdd_pkg::ST_EMPTY;
                dout_d   = '0;
              end else begin
                k_d     = '0;
                state_d = qdd_pkg::S_MARK;
              end
            end
            qdd_pkg::OP_NONE: begin
              valid_d  = 1'b1;
              status_d = qdd_pkg::ST_OK;
              dout_d   = '0;
            end
          endcase
        end
      end
      qdd_pkg::S_MARK: begin
        // compare entry k with every later entry
        ctl_o.mark = 1'b1;
        if (qdd_pkg::CNT_W'(k_q) + qdd_pkg::CNT_W'(1) >= count_q) begin
          state_d = qdd_pkg::S_COMPACT;
        end else begin
          k_d = k_q + qdd_pkg::IDX_W'(1);
        end
      end
      qdd_pkg::S_COMPACT: begin
        // squeeze out one duplicate per cycle
        if (any_dup_i) begin
          ctl_o.compact = 1'b1;
          count_d       = count_q - qdd_pkg::CNT_W'(1);
        end else begin
          valid_d  = 1'b1;
          status_d = qdd_pkg::ST_OK;
          dout_d   = '0;
          state_d  = qdd_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = qdd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qdd_pkg::S_IDLE;
      count_q <= '0;
      k_q     <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      k_q     <= k_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    dout_q   <= dout_d;
  end

  assign busy_o      = (state_q != qdd_pkg::S_IDLE);
  assign valid_o     = valid_q;
  assign status_o    = status_q;
  assign data_out_o  = dout_q;
  assign count_o     = count_q;
  assign probe_idx_o = k_q;
  assign wdata_o     = qdd_pkg::to_word(value_i);

endmodule

### sv/qdd_checker.sv
// port-level checks of the dedup queue, bound to the top level
module qdd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic [1:0]         op_i,
  input logic               valid_o,
  input logic [1:0]         status_o,
  input logic signed [31:0] data_out_o,
  input logic [4:0]         entry_count_o
);

  // enqueue, dequeue and the unused code answer on the next cycle
  a_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && op_i != qdd_pkg::OP_DEDUP) |=> valid_o)
    else $error("single-cycle transaction gave no result");

  // a result ends any dedup walk
  a_no_busy_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(valid_o && busy))
    else $error("result shown while busy");

  // full status only with every entry held
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == qdd_pkg::ST_FULL) |-> entry_count_o == 5'(qdd_pkg::DEPTH))
    else $error("full reported with free entries");

  // empty status only with nothing held
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == qdd_pkg::ST_EMPTY) |-> entry_count_o == 5'd0)
    else $error("empty reported with entries held");

  // failed transactions return zero data
  a_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o != qdd_pkg::ST_OK) |-> data_out_o == '0)
    else $error("data returned on failed transaction");

endmodule

bind fifo_queue_with_dedup qdd_checker u_qdd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .op_i          (op_i),
  .valid_o       (valid_o),
  .status_o      (status_o),
  .data_out_o    (data_out_o),
  .entry_count_o (entry_count_o)
);

### dv/testbench.sv
// self-checking testbench of the dedup queue: directed and random transactions
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned SETTLE_CYCLES  = 2 * qdd_pkg::DEPTH + 4;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned POOL_MAX       = 8;

  typedef struct {
    qdd_pkg::status_e status;
    logic [31:0]      data;
    logic [4:0]       count;
  } queue_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [1:0]         op_i;
  logic signed [31:0] value_i;
  logic               valid_o;
  logic [1:0]         status_o;
  logic signed [31:0] data_out_o;
  logic [4:0]         entry_count_o;

  // shadow copy of the queue contents
  qdd_pkg::word_t shadow_mem [qdd_pkg::DEPTH];
  int unsigned    shadow_head;
  int unsigned    shadow_count;

  queue_result_t      pending_results [$];
  int unsigned        fail_count;
  bit                 idle_enable;
  logic signed [31:0] value_pool [POOL_MAX];
  int unsigned        pool_size;

  fifo_queue_with_dedup u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .value_i       (value_i),
    .valid_o       (valid_o),
    .status_o      (status_o),
    .data_out_o    (data_out_o),
    .entry_count_o (entry_count_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // apply one operation to the shadow queue and return the result it gives
  function automatic queue_result_t predict_queue_op(qdd_pkg::op_e op,
                                                     logic signed [31:0] val);
    queue_result_t      r;
    qdd_pkg::word_t     kept [qdd_pkg::DEPTH];
    int unsigned        nkept;
    bit                 seen;
    logic signed [63:0] wide;
    qdd_pkg::word_t     w;
    r.status = qdd_pkg::ST_OK;
    r.data   = '0;
    wide     = val;
    w        = wide[qdd_pkg::DATA_WIDTH-1:0];
    case (op)
      qdd_pkg::OP_ENQ: begin
        if (shadow_count >= qdd_pkg::DEPTH) begin
          r.status = qdd_pkg::ST_FULL;
        end else begin
          shadow_mem[(shadow_head + shadow_count) % qdd_pkg::DEPTH] = w;
          shadow_count++;
        end
      end
      qdd_pkg::OP_DEQ: begin
        if (shadow_count == 0) begin
          r.status = qdd_pkg::ST_EMPTY;
        end else begin
          wide         = signed'(shadow_mem[shadow_head]);
          r.data       = wide[31:0];
          shadow_head  = (shadow_head + 1) % qdd_pkg::DEPTH;
          shadow_count--;
        end
      end
      qdd_pkg::OP_DEDUP: begin
        if (shadow_count == 0) begin
          r.status = qdd_pkg::ST_EMPTY;
        end else begin
          // keep first occurrences in queue order, then pack from the head
          nkept = 0;
          for (int i = 0; i < shadow_count; i++) begin
            w    = shadow_mem[(shadow_head + i) % qdd_pkg::DEPTH];
            seen = 1'b0;
            for (int j = 0; j < nkept; j++) begin
              if (kept[j] == w) seen = 1'b1;
            end
            if (!seen) begin
              kept[nkept] = w;
              nkept++;
            end
          end
          for (int i = 0; i < nkept; i++) begin
            shadow_mem[(shadow_head + i) % qdd_pkg::DEPTH] = kept[i];
          end
          shadow_count = nkept;
        end
      end
      default: ;
    endcase
    r.count = 5'(shadow_count);
    return r;
  endfunction

  // drive one transaction, called and returning just after a falling edge
  task automatic send_op(qdd_pkg::op_e op, logic signed [31:0] val);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    start   <= 1'b1;
    op_i    <= op;
    value_i <= val;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_results.push_back(predict_queue_op(op, val));
    @(negedge clk_i);
  endtask

  // hold off the sender until every outstanding result is back
  task automatic wait_all_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] edge_value();
    case ($urandom_range(0, 3))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sd0;
      default: return -32'sd1;
    endcase
  endfunction

  task automatic refresh_pool(int unsigned n);
    pool_size = n;
    for (int i = 0; i < POOL_MAX; i++) begin
      if ($urandom_range(0, 1) != 0) value_pool[i] = $urandom;
      else value_pool[i] = int'($urandom_range(0, 6)) - 3;
    end
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return edge_value();
      default: return value_pool[$urandom_range(0, pool_size - 1)];
    endcase
  endfunction

  // weighted random operation, enq_weight in percent of the enq/deq share
  function automatic qdd_pkg::op_e pick_op(int unsigned enq_weight);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return qdd_pkg::OP_NONE;
    if (r < 16) return qdd_pkg::OP_DEDUP;
    if (r < 16 + (enq_weight * 84) / 100) return qdd_pkg::OP_ENQ;
    return qdd_pkg::OP_DEQ;
  endfunction

  // underflow cases and the unused code on an empty queue
  task automatic test_empty_queue();
    send_op(qdd_pkg::OP_DEQ, 32'sd0);
    send_op(qdd_pkg::OP_DEDUP, 32'sh7fff_ffff);
    send_op(qdd_pkg::OP_NONE, -32'sd1);
    wait_all_results();
  endtask

  // extreme words with repeats, dedup with and without repeats, drain past empty
  task automatic test_edge_values();
    send_op(qdd_pkg::OP_ENQ, 32'sh8000_0000);
    send_op(qdd_pkg::OP_ENQ, 32'sh7fff_ffff);
    send_op(qdd_pkg::OP_ENQ, 32'sd0);
    send_op(qdd_pkg::OP_ENQ, 32'sh8000_0000);
    send_op(qdd_pkg::OP_ENQ, -32'sd1);
    send_op(qdd_pkg::OP_ENQ, 32'sh7fff_ffff);
    send_op(qdd_pkg::OP_ENQ, 32'sh5555_5555);
    send_op(qdd_pkg::OP_ENQ, 32'shaaaa_aaaa);
    send_op(qdd_pkg::OP_DEDUP, 32'sd0);
    send_op(qdd_pkg::OP_DEDUP, -32'sd1);
    repeat (7) send_op(qdd_pkg::OP_DEQ, $urandom);
    wait_all_results();
  endtask

  // full queue: overflow, dedup to one entry, dedup of distinct words, drain
  task automatic test_full_queue();
    logic signed [31:0] same;
    same = $urandom;
    repeat (qdd_pkg::DEPTH) send_op(qdd_pkg::OP_ENQ, same);
    send_op(qdd_pkg::OP_ENQ, $urandom);
    send_op(qdd_pkg::OP_DEDUP, 32'sd0);
    while (shadow_count < qdd_pkg::DEPTH) send_op(qdd_pkg::OP_ENQ, $urandom);
    send_op(qdd_pkg::OP_ENQ, $urandom);
    send_op(qdd_pkg::OP_ENQ, edge_value());
    send_op(qdd_pkg::OP_NONE, $urandom);
    send_op(qdd_pkg::OP_DEDUP, $urandom);
    while (shadow_count != 0) send_op(qdd_pkg::OP_DEQ, $urandom);
    send_op(qdd_pkg::OP_DEQ, $urandom);
    wait_all_results();
  endtask

  // fill from a small pool of words, remove repeats, then dequeue part of it
  task automatic test_dedup_rounds();
    int unsigned n;
    int unsigned k;
    for (int round = 0; round < 45; round++) begin
      refresh_pool($urandom_range(1, 6));
      n = $urandom_range(1, qdd_pkg::DEPTH);
      for (int i = 0; i < n; i++) begin
        k = $urandom_range(0, 11);
        // occasional noise and early dedup inside the sequence
        if (k == 0) send_op(qdd_pkg::op_e'($urandom_range(0, 3)), $urandom);
        else if (k == 1) send_op(qdd_pkg::OP_DEDUP, $urandom);
        else send_op(qdd_pkg::OP_ENQ, value_pool[$urandom_range(0, pool_size - 1)]);
      end
      send_op(qdd_pkg::OP_DEDUP, $urandom);
      k = $urandom_range(0, shadow_count);
      repeat (k) send_op(qdd_pkg::OP_DEQ, $urandom);
      if (round % 15 == 14) wait_all_results();
    end
    wait_all_results();
  endtask

  // random mix in chunks that lean towards filling or emptying
  task automatic test_random_mix();
    int unsigned enq_weight;
    for (int chunk = 0; chunk < 9; chunk++) begin
      enq_weight = $urandom_range(30, 75);
      refresh_pool($urandom_range(2, POOL_MAX));
      repeat (100) send_op(pick_op(enq_weight), pick_value());
    end
    wait_all_results();
  endtask

  // transactions on every free cycle, no idling
  task automatic test_back_to_back();
    idle_enable = 1'b0;
    refresh_pool(4);
    repeat (150) send_op(pick_op(55), pick_value());
    wait_all_results();
  endtask

  // result checker
  always @(posedge clk_i) begin
    queue_result_t exp_r;
    if (rst_ni && valid_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: status %0d data %h count %0d", $time,
                 status_o, data_out_o, entry_count_o);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (status_o !== exp_r.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d", $time,
                   exp_r.status, status_o);
          fail_count++;
        end
        if (data_out_o !== exp_r.data) begin
          $display("%0t: data_out mismatch: expected %h actual %h", $time,
                   exp_r.data, data_out_o);
          fail_count++;
        end
        if (entry_count_o !== exp_r.count) begin
          $display("%0t: entry_count mismatch: expected %0d actual %0d", $time,
                   exp_r.count, entry_count_o);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction and no result
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (start && !busy) || valid_o) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: watchdog expired", $time);
    $display("Some tests failed");
    $finish;
  end

  // sequence of tests
  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    op_i         = qdd_pkg::OP_NONE;
    value_i      = '0;
    fail_count   = 0;
    idle_enable  = 1'b1;
    shadow_head  = 0;
    shadow_count = 0;
    for (int i = 0; i < qdd_pkg::DEPTH; i++) shadow_mem[i] = '0;
    refresh_pool(4);
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_queue();
    test_edge_values();
    test_full_queue();
    test_dedup_rounds();
    test_random_mix();
    test_back_to_back();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
